### hw/rtl/hrc_pkg.sv
// ----------------------------------------------------------------------------
// hrc_pkg
// Shared widths, constants and register codes of the heading reversal counter.
// ----------------------------------------------------------------------------
package hrc_pkg;

    // Field widths
    localparam int HEAD_W  = 15;
    localparam int TOL_W   = 14;
    localparam int COUNT_W = 16;

    // Configuration port geometry
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // Default structural parameters
    localparam int WINDOW_DEF = 5;
    localparam int LEAP_DEF   = 5;

    // 180 degrees in 1/64 degree units
    localparam logic [HEAD_W-1:0] HALF_TURN = HEAD_W'(11520);

    // Register reset values and limits
    localparam logic [TOL_W-1:0]   TOL_RESET = TOL_W'(128);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Register word index (paddr[2])
    localparam logic REG_TOLERANCE = 1'b0;

endpackage

### hw/rtl/heading_reversal_counter.sv
// Path: an accepted item passes the input register, then the result register.
// Throughput: one item per cycle while the result side takes each result (i_ready high).
// While a result waits, one more item enters the input register, then input stalls.
// Reset (i_rst_n low, synchronous) clears the counters and sets tolerance to 128;
// the last-sample flag clears trajectory state after its result.
// ----------------------------------------------------------------------------
// heading_reversal_counter
// Counts heading reversals per trajectory in a stream of heading samples.
// ----------------------------------------------------------------------------
module heading_reversal_counter #(
    parameter int WINDOW = hrc_pkg::WINDOW_DEF,
    parameter int LEAP   = hrc_pkg::LEAP_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hrc_pkg::ADDR_W-1:0]   paddr,
    input  logic [hrc_pkg::DATA_W-1:0]   pwdata,
    output logic [hrc_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [hrc_pkg::HEAD_W-1:0]   i_heading,
    input  logic                         i_last_sample,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [hrc_pkg::COUNT_W-1:0]  o_turn_count,
    output logic                         o_reversal_seen,
    output logic                         o_final_res
);

    logic [hrc_pkg::TOL_W-1:0] tolerance;

    // Configuration registers
    hrc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_tolerance (tolerance)
    );

    // Reversal datapath
    hrc_core #(
        .WINDOW (WINDOW),
        .LEAP   (LEAP)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_tolerance     (tolerance),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_heading       (i_heading),
        .i_last_sample   (i_last_sample),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_turn_count    (o_turn_count),
        .o_reversal_seen (o_reversal_seen),
        .o_final_res     (o_final_res)
    );

endmodule

### hw/rtl/hrc_cfg.sv
// ----------------------------------------------------------------------------
// hrc_cfg
// APB-style register file holding the tolerance register.
// ----------------------------------------------------------------------------
module hrc_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hrc_pkg::ADDR_W-1:0]  paddr,
    input  logic [hrc_pkg::DATA_W-1:0]  pwdata,
    output logic [hrc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output logic [hrc_pkg::TOL_W-1:0]   o_tolerance
);

    logic [hrc_pkg::TOL_W-1:0] r_tolerance;
    logic                      wr_tol;

    // Never stall the bus
    assign pready = 1'b1;

    // Decode a completed write to the tolerance word
    assign wr_tol = psel && penable && pwrite && pready
                    && (paddr[2] == hrc_pkg::REG_TOLERANCE);

    // Hold the tolerance register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance <= hrc_pkg::TOL_RESET;
        end else if (wr_tol) begin
            r_tolerance <= pwdata[hrc_pkg::TOL_W-1:0];
        end
    end

    // Return the register on reads, zero elsewhere
    always_comb begin
        prdata = '0;
        if (paddr[2] == hrc_pkg::REG_TOLERANCE) begin
            prdata = {{(hrc_pkg::DATA_W-hrc_pkg::TOL_W){1'b0}}, r_tolerance};
        end
    end

    assign o_tolerance = r_tolerance;

endmodule

### hw/rtl/hrc_core.sv
// ----------------------------------------------------------------------------
// hrc_core
// Input register, delay line, reversal test and result register.
// ----------------------------------------------------------------------------
module hrc_core #(
    parameter int WINDOW = hrc_pkg::WINDOW_DEF,
    parameter int LEAP   = hrc_pkg::LEAP_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [hrc_pkg::TOL_W-1:0]    i_tolerance,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [hrc_pkg::HEAD_W-1:0]   i_heading,
    input  logic                         i_last_sample,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [hrc_pkg::COUNT_W-1:0]  o_turn_count,
    output logic                         o_reversal_seen,
    output logic                         o_final_res
);

    localparam int POS_W  = $clog2(WINDOW + 1);
    localparam int SKIP_W = (LEAP > 1) ? $clog2(LEAP) : 1;
    localparam logic [POS_W-1:0]  POS_FULL  = POS_W'(WINDOW);
    localparam logic [SKIP_W-1:0] SKIP_LOAD = SKIP_W'(LEAP - 1);

    // Input stage
    logic                        r_s1_valid;
    logic [hrc_pkg::HEAD_W-1:0]  r_s1_heading;
    logic                        r_s1_last;

    // Trajectory state
    logic [hrc_pkg::HEAD_W-1:0]  r_delay [WINDOW];
    logic [POS_W-1:0]            r_pos, n_pos;
    logic [SKIP_W-1:0]           r_skip, n_skip;
    logic                        r_matched, n_matched;
    logic [hrc_pkg::COUNT_W-1:0] r_total, n_total;

    // Result stage
    logic                        r_out_valid;
    logic [hrc_pkg::COUNT_W-1:0] r_out_count;
    logic                        r_out_seen, n_seen;
    logic                        r_out_final;

    logic                        s1_move;
    logic [hrc_pkg::HEAD_W-1:0]  head_diff;
    logic [hrc_pkg::HEAD_W-1:0]  turn_err;
    logic                        is_match;

    // Advance the input stage when the result register is free
    assign s1_move = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_move;

    // Capture the incoming item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s1_heading <= i_heading;
            r_s1_last    <= i_last_sample;
        end
    end

    // Compare against the sample a window back
    always_comb begin
        if (r_s1_heading >= r_delay[WINDOW-1]) begin
            head_diff = r_s1_heading - r_delay[WINDOW-1];
        end else begin
            head_diff = r_delay[WINDOW-1] - r_s1_heading;
        end
        if (head_diff >= hrc_pkg::HALF_TURN) begin
            turn_err = head_diff - hrc_pkg::HALF_TURN;
        end else begin
            turn_err = hrc_pkg::HALF_TURN - head_diff;
        end
        is_match = turn_err < {1'b0, i_tolerance};
    end

    // Next trajectory state and match flag
    always_comb begin
        n_pos     = r_pos;
        n_skip    = r_skip;
        n_matched = r_matched;
        n_total   = r_total;
        n_seen    = 1'b0;
        if (r_pos == POS_FULL) begin
            if (r_skip != '0) begin
                n_skip = r_skip - SKIP_W'(1);
            end else if (is_match) begin
                n_seen    = 1'b1;
                n_matched = 1'b1;
                n_skip    = SKIP_LOAD;
                if (!r_matched && (r_total != hrc_pkg::COUNT_MAX)) begin
                    n_total = r_total + hrc_pkg::COUNT_W'(1);
                end
            end else begin
                n_matched = 1'b0;
            end
        end else begin
            n_pos = r_pos + POS_W'(1);
        end
    end

    // Update state; drop it all after the last sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_skip    <= '0;
            r_matched <= 1'b0;
            r_total   <= '0;
        end else if (s1_move) begin
            if (r_s1_last) begin
                r_pos     <= '0;
                r_skip    <= '0;
                r_matched <= 1'b0;
                r_total   <= '0;
            end else begin
                r_pos     <= n_pos;
                r_skip    <= n_skip;
                r_matched <= n_matched;
                r_total   <= n_total;
            end
        end
    end

    // Shift the heading delay line
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_delay[0] <= r_s1_heading;
            for (int i = 1; i < WINDOW; i++) begin
                r_delay[i] <= r_delay[i-1];
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_count <= n_total;
            r_out_seen  <= n_seen;
            r_out_final <= r_s1_last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_turn_count    = r_out_count;
    assign o_reversal_seen = r_out_seen;
    assign o_final_res     = r_out_final;

endmodule

### dv/heading_reversal_counter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_reversal_counter_tb
// Self-checking bench for the heading reversal counter. It streams trajectories
// of headings through the valid/ready input, predicts every result with its own
// model of the window compare, skip and count logic, and checks each result in
// order. Tolerance is changed over APB between phases, extremes included.
// ----------------------------------------------------------------------------
module heading_reversal_counter_tb;

    localparam int TRACK_WINDOW   = hrc_pkg::WINDOW_DEF;
    localparam int SKIP_SPAN      = hrc_pkg::LEAP_DEF;
    localparam int HEAD_MAX       = (1 << hrc_pkg::HEAD_W) - 1;
    localparam int HEAD_RANGE_MAX = 23039;
    localparam int TOL_MAX        = (1 << hrc_pkg::TOL_W) - 1;
    localparam int DRAIN_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [hrc_pkg::COUNT_W-1:0] turn_count;
        logic                        reversal_seen;
        logic                        final_res;
    } t_turn_result;

    // heading shapes relative to the sample one window back
    typedef enum {SHAPE_FREE, SHAPE_MATCH, SHAPE_EDGE, SHAPE_MISS} t_shape;

    // ------------------------------------------------------------------------
    // Reversal predictor and result checker
    // ------------------------------------------------------------------------
    class reversal_scoreboard;
        logic [hrc_pkg::HEAD_W-1:0]  delay_line [TRACK_WINDOW];
        int unsigned                 slot;
        int unsigned                 seen_count;
        int unsigned                 skips_left;
        bit                          matched_last;
        logic [hrc_pkg::COUNT_W-1:0] turns;
        logic [hrc_pkg::TOL_W-1:0]   tol;
        t_turn_result                expected_q [$];
        int unsigned                 failures;

        function new();
            tol      = hrc_pkg::TOL_RESET;
            failures = 0;
            clear_track();
        endfunction

        function void clear_track();
            foreach (delay_line[i]) delay_line[i] = '0;
            slot         = 0;
            seen_count   = 0;
            skips_left   = 0;
            matched_last = 1'b0;
            turns        = '0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void flag(string what, longint want, longint got);
            failures++;
            if (failures <= REPORT_LIMIT) begin
                $display("[%0t] mismatch %s: expected %0d, got %0d", $time, what, want, got);
            end
        endfunction

        // Advance the track state by one accepted sample and queue its result
        function void note_sample(logic [hrc_pkg::HEAD_W-1:0] heading, logic last);
            int unsigned  old_heading;
            int unsigned  d;
            int unsigned  gap;
            bit           hit;
            t_turn_result r;
            hit = 1'b0;
            if (seen_count >= TRACK_WINDOW) begin
                if (skips_left > 0) begin
                    skips_left--;
                end else begin
                    old_heading = delay_line[slot];
                    d = (heading >= old_heading) ? heading - old_heading
                                                 : old_heading - heading;
                    gap = (d >= hrc_pkg::HALF_TURN) ? d - hrc_pkg::HALF_TURN
                                                    : hrc_pkg::HALF_TURN - d;
                    if (gap < tol) begin
                        hit = 1'b1;
                        if (!matched_last && turns != hrc_pkg::COUNT_MAX) turns++;
                        matched_last = 1'b1;
                        skips_left   = SKIP_SPAN - 1;
                    end else begin
                        matched_last = 1'b0;
                    end
                end
            end
            delay_line[slot] = heading;
            slot = (slot + 1) % TRACK_WINDOW;
            if (seen_count < TRACK_WINDOW) seen_count++;
            r.turn_count    = turns;
            r.reversal_seen = hit;
            r.final_res     = last;
            expected_q.push_back(r);
            if (last) clear_track();
        endfunction

        // Compare one delivered result against the oldest prediction
        function void check_result(logic [hrc_pkg::COUNT_W-1:0] cnt, logic seen, logic fin);
            t_turn_result want;
            if (expected_q.size() == 0) begin
                flag("result with nothing pending, turn_count", -1, cnt);
                return;
            end
            want = expected_q.pop_front();
            if (cnt !== want.turn_count) flag("turn_count", want.turn_count, cnt);
            if (seen !== want.reversal_seen) flag("reversal_seen", want.reversal_seen, seen);
            if (fin !== want.final_res) flag("final_res", want.final_res, fin);
        endfunction
    endclass

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [hrc_pkg::ADDR_W-1:0]  paddr;
    logic [hrc_pkg::DATA_W-1:0]  pwdata;
    logic [hrc_pkg::DATA_W-1:0]  prdata;
    logic                        pready;
    logic                        i_valid;
    logic                        o_ready;
    logic [hrc_pkg::HEAD_W-1:0]  i_heading;
    logic                        i_last_sample;
    logic                        o_valid;
    logic                        i_ready;
    logic [hrc_pkg::COUNT_W-1:0] o_turn_count;
    logic                        o_reversal_seen;
    logic                        o_final_res;

    reversal_scoreboard          sb;
    logic [hrc_pkg::HEAD_W-1:0]  trail [$];
    int                          cur_tol;
    bit                          no_idle;
    int                          quiet_cycles;

    heading_reversal_counter u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_heading       (i_heading),
        .i_last_sample   (i_last_sample),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_turn_count    (o_turn_count),
        .o_reversal_seen (o_reversal_seen),
        .o_final_res     (o_final_res)
    );

    // Run the clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Accept results, check them, and stall the result side at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result(o_turn_count, o_reversal_seen, o_final_res);
        end
        i_ready <= no_idle || ($urandom_range(0, 99) >= 13);
    end

    // Drop the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("heading_reversal_counter verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One APB transfer: setup phase, access phase until pready, then the bus returns to idle
    task automatic apb_access(input bit is_write, input logic [hrc_pkg::ADDR_W-1:0] addr,
                              input logic [hrc_pkg::DATA_W-1:0] wdata,
                              output logic [hrc_pkg::DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Hold off until every expected result is back, then idle for the DRAIN_CYCLES margin
    task automatic drain_results();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write the tolerance register while idle and read it back
    task automatic set_tolerance(input int value);
        logic [hrc_pkg::ADDR_W-1:0] addr;
        logic [hrc_pkg::DATA_W-1:0] rdata;
        addr = hrc_pkg::ADDR_W'({hrc_pkg::REG_TOLERANCE, 2'b00});
        drain_results();
        apb_access(1'b1, addr, hrc_pkg::DATA_W'(value), rdata);
        sb.tol  = hrc_pkg::TOL_W'(value);
        cur_tol = value;
        apb_access(1'b0, addr, '0, rdata);
        if (rdata !== hrc_pkg::DATA_W'(value)) sb.flag("tolerance readback", value, rdata);
    endtask

    // Offer one sample, wait for it to be taken, then note it
    task automatic send_sample(input logic [hrc_pkg::HEAD_W-1:0] heading, input logic last);
        while (!no_idle && $urandom_range(0, 99) < 13) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_heading     <= heading;
        i_last_sample <= last;
        do @(posedge i_clk); while (!o_ready);
        sb.note_sample(heading, last);
        trail.push_back(heading);
        if (trail.size() > TRACK_WINDOW) void'(trail.pop_front());
        if (last) trail.delete();
    endtask

    // Pick a heading that hits, grazes or misses a reversal against the
    // sample one window back
    function automatic logic [hrc_pkg::HEAD_W-1:0] shape_heading(t_shape kind);
        int base;
        int off;
        int span;
        int up;
        int dn;
        if (trail.size() < TRACK_WINDOW || kind == SHAPE_FREE) begin
            return ($urandom_range(0, 99) < 15)
                   ? hrc_pkg::HEAD_W'($urandom_range(0, HEAD_MAX))
                   : hrc_pkg::HEAD_W'($urandom_range(0, HEAD_RANGE_MAX));
        end
        base = trail[0];
        case (kind)
            SHAPE_MISS:  return hrc_pkg::HEAD_W'(base);
            SHAPE_MATCH: off = (cur_tol > 0) ? $urandom_range(0, cur_tol - 1) : 0;
            default:     off = ($urandom_range(0, 1) && cur_tol > 0) ? cur_tol - 1 : cur_tol;
        endcase
        span = int'(hrc_pkg::HALF_TURN) - off;
        if (span < 0 || $urandom_range(0, 1)) span = int'(hrc_pkg::HALF_TURN) + off;
        up = base + span;
        dn = base - span;
        if (up <= HEAD_MAX && (dn < 0 || $urandom_range(0, 1))) return hrc_pkg::HEAD_W'(up);
        if (dn >= 0) return hrc_pkg::HEAD_W'(dn);
        return hrc_pkg::HEAD_W'($urandom_range(0, HEAD_MAX));
    endfunction

    // Stream whole trajectories of mixed shape, mostly well-formed
    task automatic run_tracks(input int n_items);
        int     sent;
        int     len;
        int     r;
        t_shape kind;
        sent = 0;
        while (sent < n_items) begin
            r   = $urandom_range(0, 9);
            len = (r < 7) ? $urandom_range(TRACK_WINDOW + 1, 30)
                : (r < 9) ? $urandom_range(1, TRACK_WINDOW) : $urandom_range(31, 60);
            for (int k = 0; k < len; k++) begin
                r    = $urandom_range(0, 99);
                kind = (r < 35) ? SHAPE_MATCH : (r < 45) ? SHAPE_EDGE
                     : (r < 60) ? SHAPE_MISS : SHAPE_FREE;
                send_sample(shape_heading(kind), k == len - 1);
                sent++;
            end
        end
    endtask

    // Main sequence
    initial begin
        logic [hrc_pkg::HEAD_W-1:0] early [TRACK_WINDOW] = '{15'd0, 15'h7FFF, 15'h5555,
                                                             15'h2AAA, 15'd23039};
        t_shape plan [15] = '{SHAPE_MATCH, SHAPE_FREE, SHAPE_FREE, SHAPE_FREE, SHAPE_FREE,
                              SHAPE_MATCH, SHAPE_MISS, SHAPE_MATCH, SHAPE_MISS, SHAPE_MISS,
                              SHAPE_MISS, SHAPE_MISS, SHAPE_EDGE, SHAPE_EDGE, SHAPE_MISS};
        sb            = new();
        cur_tol       = hrc_pkg::TOL_RESET;
        no_idle       = 1'b0;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_valid       = 1'b0;
        i_heading     = '0;
        i_last_sample = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: lone last sample, early samples, match, skip, repeat, boundary
        send_sample(15'h7FFF, 1'b1);
        foreach (early[i]) send_sample(early[i], 1'b0);
        foreach (plan[i]) send_sample(shape_heading(plan[i]), i == 14);

        // Random trajectories across tolerance settings
        set_tolerance(0);
        run_tracks(130);
        set_tolerance(TOL_MAX);
        run_tracks(130);
        set_tolerance(int'(hrc_pkg::HALF_TURN));
        run_tracks(130);
        for (int p = 0; p < 3; p++) begin
            set_tolerance($urandom_range(2, 900));
            no_idle = (p == 1);
            run_tracks(140);
        end
        no_idle = 1'b0;
        set_tolerance(1);
        run_tracks(110);

        drain_results();
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("heading_reversal_counter verification clean");
        end else begin
            $display("heading_reversal_counter verification failed");
        end
        $finish;
    end

endmodule
